// ===== design/zero_run_length_byte_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// Zero-run-length byte encoder assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ZERO_RUN_LENGTH_BYTE_ENCODER_DEFINES_SVH
`define ZERO_RUN_LENGTH_BYTE_ENCODER_DEFINES_SVH

// Same-cycle implication
`define ZRLE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define ZRLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/zrle_pkg.sv =====
// ----------------------------------------------------------------------------
// Zero-run-length byte encoder package
// Function codes, run constants and the types shared between the parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package zrle_pkg;

   localparam logic [1:0] FUNC_BIT    = 2'd0;
   localparam logic [1:0] FUNC_BYTE   = 2'd1;
   localparam logic [1:0] FUNC_EOR    = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic [7:0] RUN_FULL     = 8'd255;
   localparam logic [2:0] BYTE_LAST_IX = 3'd7;

   // One queued command: bits to shift out LSB first, or an end of record
   typedef struct packed {
      logic       eor;
      logic [7:0] bits;
      logic [2:0] left;   // bits still to follow after the first one
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

endpackage

`default_nettype wire

// ===== design/zrle_if.sv =====
// ----------------------------------------------------------------------------
// Zero-run-length byte encoder channels
// Valid/ready channels for request items and run-byte result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface zrle_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] data_byte;

   modport source (output valid, output func, output data_byte, input ready);
   modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface zrle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] run_byte;
   logic       last;

   modport source (output valid, output run_byte, output last, input ready);
   modport sink   (input valid, input run_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== design/zrle_front.sv =====
// ----------------------------------------------------------------------------
// Zero-run-length front end
// Accepts request items, drops unused codes and turns the rest into queue
// commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zrle_front (
   zrle_req_if.sink                 req,
   input  zrle_pkg::queue_status_type q_status,
   output logic                     push,
   output zrle_pkg::queue_entry_type push_entry
);

   logic keep;

   assign req.ready = !q_status.full;
   assign push      = req.valid && req.ready && keep;

   always_comb begin
      keep       = 1'b1;
      push_entry = '0;
      case (req.func)
         zrle_pkg::FUNC_BIT: begin
            // only bit 0 counts
            push_entry.bits = {7'd0, req.data_byte[0]};
            push_entry.left = 3'd0;
         end
         zrle_pkg::FUNC_BYTE: begin
            push_entry.bits = req.data_byte;
            push_entry.left = zrle_pkg::BYTE_LAST_IX;
         end
         zrle_pkg::FUNC_EOR: begin
            push_entry.eor = 1'b1;
         end
         default: begin
            // drop: no result and no state change
            keep = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/zrle_queue.sv =====
// ----------------------------------------------------------------------------
// Zero-run-length command queue
// Small FIFO that decouples the front end from the run encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zrle_queue #(
   parameter int DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  zrle_pkg::queue_entry_type push_entry,
   input  logic                      pop,
   output zrle_pkg::queue_entry_type pop_entry,
   output zrle_pkg::queue_status_type status
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   zrle_pkg::queue_entry_type entry_ff [DEPTH];

   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_entry    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== design/zrle_back.sv =====
// ----------------------------------------------------------------------------
// Zero-run-length back end
// Shifts queued bits through the zero-run counter one per cycle unless a
// waiting result stalls it, and emits run bytes into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zrle_back (
   input  logic                       clock,
   input  logic                       reset,
   input  zrle_pkg::queue_entry_type  pop_entry,
   input  zrle_pkg::queue_status_type q_status,
   output logic                       pop,
   zrle_rsp_if.source                 rsp
);

   zrle_pkg::back_state_type state_ff, state_in;

   logic [7:0] count_ff, count_in;
   logic [7:0] bits_ff, bits_in;
   logic [2:0] left_ff, left_in;
   logic       eor_ff, eor_in;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;

   logic       emit;
   logic       more;
   logic       advance;
   logic       slot_free;
   logic [7:0] result;
   logic [7:0] count_inc;
   logic [7:0] count_step;
   logic [8:0] zeros_ahead;

   assign rsp.valid    = out_valid_ff;
   assign rsp.run_byte = out_byte_ff;
   assign rsp.last     = out_last_ff;

   assign slot_free = !out_valid_ff || rsp.ready;
   assign count_inc = count_ff + 8'd1;

   // one bit or one end of record per cycle, unless a waiting result stalls it
   always_comb begin
      emit       = 1'b0;
      result     = count_ff;
      count_step = count_inc;
      if (eor_ff) begin
         emit       = 1'b1;
         count_step = '0;
      end else if (bits_ff[0]) begin
         emit       = 1'b1;
         count_step = '0;
      end else if (count_inc == zrle_pkg::RUN_FULL) begin
         emit       = 1'b1;
         result     = zrle_pkg::RUN_FULL;
         count_step = '0;
      end
   end

   // a later bit of this item still yields a byte if a one follows or the
   // remaining zeros fill a run
   assign zeros_ahead = {1'b0, count_step} + {6'd0, left_ff};
   assign more = !eor_ff && ((|bits_ff[7:1]) || (zeros_ahead >= {1'b0, zrle_pkg::RUN_FULL}));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         zrle_pkg::BACK_IDLE: begin
            if (!q_status.empty) begin
               state_in = zrle_pkg::BACK_RUN;
            end
         end
         zrle_pkg::BACK_RUN: begin
            if (advance && (eor_ff || left_ff == '0)) begin
               state_in = zrle_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = zrle_pkg::BACK_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      pop     = 1'b0;
      advance = 1'b0;
      case (state_ff)
         zrle_pkg::BACK_IDLE: begin
            pop = !q_status.empty;
         end
         zrle_pkg::BACK_RUN: begin
            advance = !emit || slot_free;
         end
         default: begin
            pop     = 1'b0;
            advance = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      bits_in  = bits_ff;
      left_in  = left_ff;
      eor_in   = eor_ff;
      if (pop) begin
         bits_in = pop_entry.bits;
         left_in = pop_entry.left;
         eor_in  = pop_entry.eor;
      end else if (advance) begin
         count_in = count_step;
         bits_in  = {1'b0, bits_ff[7:1]};
         left_in  = left_ff - 3'd1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (advance && emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = result;
         out_last_in  = !more;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= zrle_pkg::BACK_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff     <= bits_in;
      left_ff     <= left_in;
      eor_ff      <= eor_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

endmodule

`default_nettype wire

// ===== design/zero_run_length_byte_encoder.sv =====
// Zero-run-length byte encoder. Request items (one bit, a byte taken LSB
// first, or an end of record) pass through a small command queue to a run
// encoder that handles one bit per cycle while no result stalls it: it
// fetches a command while idle, then works through a single bit, the
// eight bits of a byte, or an end of record, before the next fetch. Each result
// byte sits in an output register; a stalled result holds the encoder but the
// queue keeps taking requests until it is full. The last flag marks the
// final byte an item produces; items that produce nothing give no result.
`timescale 1ns / 1ps
`default_nettype none
`include "zero_run_length_byte_encoder_defines.svh"

// ----------------------------------------------------------------------------
// Zero-run-length byte encoder top level
// Front end, command queue and run encoder joined into one block.
// ----------------------------------------------------------------------------
module zero_run_length_byte_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   zrle_req_if.sink   req,
   zrle_rsp_if.source rsp
);

   zrle_pkg::queue_entry_type  push_entry;
   zrle_pkg::queue_entry_type  pop_entry;
   zrle_pkg::queue_status_type q_status;
   logic                       push;
   logic                       pop;

   zrle_front u_front (
      .req        (req),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   zrle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   zrle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_entry (pop_entry),
      .q_status  (q_status),
      .pop       (pop),
      .rsp       (rsp)
   );

   `ZRLE_ASSERT_SAME(a_push_not_full, push, !q_status.full, "push into full queue")
   `ZRLE_ASSERT_SAME(a_pop_not_empty, pop, !q_status.empty, "pop from empty queue")
   `ZRLE_ASSERT_SAME(a_drop_unused, req.func == zrle_pkg::FUNC_UNUSED, !push, "unused queued")
   `ZRLE_ASSERT_NEXT(a_rsp_hold, rsp.valid && !rsp.ready, $stable(rsp.run_byte), "result changed")

endmodule

`default_nettype wire
